FILE: rtl/ctq_pkg.sv
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared widths, codes, entry type and pointer helper for the connection
// timeout queue.
// ----------------------------------------------------------------------------
package ctq_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int PTR_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int OP_W        = 2;
    localparam int ID_W        = 16;
    localparam int SEQ_W       = 32;
    localparam int TIME_W      = 32;
    localparam int WAIT_W      = 16;
    localparam int KIND_W      = 2;
    localparam int CNT_OUT_W   = 7;
    localparam int CFG_IDX_W   = 1;

    typedef logic [OP_W-1:0]      t_opcode;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_opcode OP_ADD   = 2'd0;
    localparam t_opcode OP_DEL   = 2'd1;
    localparam t_opcode OP_POLL  = 2'd2;
    localparam t_opcode OP_CLEAR = 2'd3;

    localparam t_kind KIND_DONE    = 2'd0;
    localparam t_kind KIND_EXPIRED = 2'd1;
    localparam t_kind KIND_FULL    = 2'd2;
    localparam t_kind KIND_NONE    = 2'd3;

    localparam t_cfg_idx CFG_WAIT_TIME = 1'd0;
    localparam t_cfg_idx CFG_KICK      = 1'd1;

    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd20;
    localparam logic              KICK_RESET = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   conn;
        logic [SEQ_W-1:0]  seq;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_entry           wdata;
        logic [PTR_W-1:0] raddr;
    } t_mem_req;

    // circular add of two slot indexes, both below TABLE_DEPTH
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(TABLE_DEPTH)) begin
            s = s - (PTR_W+1)'(TABLE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/ctq_item_if.sv
// ----------------------------------------------------------------------------
// ctq_item_if
// Operation channel of the connection timeout queue.
// ----------------------------------------------------------------------------
interface ctq_item_if import ctq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   conn_id;
    logic [SEQ_W-1:0]  conn_sequence;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output opcode, output conn_id, output conn_sequence,
                    output now_seconds, input ready);
    modport sink   (input valid, input opcode, input conn_id, input conn_sequence,
                    input now_seconds, output ready);
endinterface

FILE: rtl/ctq_result_if.sv
// ----------------------------------------------------------------------------
// ctq_result_if
// Result channel of the connection timeout queue.
// ----------------------------------------------------------------------------
interface ctq_result_if import ctq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      out_conn_id;
    logic [SEQ_W-1:0]     out_sequence;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [TIME_W-1:0]    earliest_expiry;
    logic                 last;

    modport source (output valid, output kind, output out_conn_id, output out_sequence,
                    output entry_count, output earliest_expiry, output last, input ready);
    modport sink   (input valid, input kind, input out_conn_id, input out_sequence,
                    input entry_count, input earliest_expiry, input last, output ready);
endinterface

FILE: rtl/ctq_cfg_if.sv
// ----------------------------------------------------------------------------
// ctq_cfg_if
// Register write channel of the connection timeout queue.
// ----------------------------------------------------------------------------
interface ctq_cfg_if import ctq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WAIT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ctq_table.sv
// ----------------------------------------------------------------------------
// ctq_table
// Timer entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ctq_table import ctq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry mem [0:TABLE_DEPTH-1];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ctq_ctrl.sv
// ----------------------------------------------------------------------------
// ctq_ctrl
// Sequencer that walks the sorted timer table one slot per step, using a
// single expiry comparator, and the result output register.
// ----------------------------------------------------------------------------
module ctq_ctrl import ctq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WAIT_W-1:0] i_wait_time,
    input  logic              i_kick,
    ctq_item_if.sink          i_item,
    ctq_result_if.source      o_result,
    output t_mem_req          o_mem,
    input  t_entry            i_rd_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PUT      = 4'd1;
    localparam logic [3:0] S_INS      = 4'd2;
    localparam logic [3:0] S_INS_CMP  = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_CHK  = 4'd5;
    localparam logic [3:0] S_POLL_RD  = 4'd6;
    localparam logic [3:0] S_POLL_POP = 4'd7;
    localparam logic [3:0] S_POLL_REF = 4'd8;
    localparam logic [3:0] S_POLL_REFW = 4'd9;

    logic [3:0]           r_state, n_state;
    t_opcode              r_op, n_op;
    logic [ID_W-1:0]      r_id, n_id;
    logic [TIME_W-1:0]    r_now, n_now;
    logic [TIME_W-1:0]    r_exp, n_exp;
    t_entry               r_ins, n_ins;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [TIME_W-1:0]    r_head_exp, n_head_exp;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_p, n_p;
    logic [CNT_W-1:0]     r_r, n_r;
    logic [CNT_W-1:0]     r_w, n_w;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_start, n_start;
    t_kind                r_res_kind, n_res_kind;
    logic [ID_W-1:0]      r_res_conn, n_res_conn;
    logic [SEQ_W-1:0]     r_res_seq, n_res_seq;
    logic                 r_res_last, n_res_last;

    logic                 r_out_valid, n_out_valid;
    t_kind                r_out_kind, n_out_kind;
    logic [ID_W-1:0]      r_out_conn, n_out_conn;
    logic [SEQ_W-1:0]     r_out_seq, n_out_seq;
    logic [CNT_OUT_W-1:0] r_out_count, n_out_count;
    logic [TIME_W-1:0]    r_out_earliest, n_out_earliest;
    logic                 r_out_last, n_out_last;

    logic [TIME_W:0]      exp_sum;
    logic [TIME_W-1:0]    exp_new;
    logic [TIME_W-1:0]    cmp_a;
    logic [TIME_W-1:0]    cmp_b;
    logic                 cmp_gt;
    t_mem_req             mem;

    function automatic logic [PTR_W-1:0] laddr(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] l);
        return ptr_add(head, l[PTR_W-1:0]);
    endfunction

    // saturating expiry for arming at the current time
    assign exp_sum = {1'b0, i_item.now_seconds} + (TIME_W+1)'(i_wait_time);
    assign exp_new = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

    // the one expiry comparator, shared by the idle, insert and poll steps
    always_comb begin
        cmp_a = i_rd_data.expiry;
        cmp_b = r_now;
        case (r_state)
            S_IDLE: begin
                cmp_a = r_head_exp;
                cmp_b = i_item.now_seconds;
            end
            S_INS_CMP: begin
                cmp_b = r_ins.expiry;
            end
            default: begin
                cmp_b = r_now;
            end
        endcase
    end
    assign cmp_gt = cmp_a > cmp_b;

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_id           = r_id;
        n_now          = r_now;
        n_exp          = r_exp;
        n_ins          = r_ins;
        n_head         = r_head;
        n_head_exp     = r_head_exp;
        n_count        = r_count;
        n_p            = r_p;
        n_r            = r_r;
        n_w            = r_w;
        n_i            = r_i;
        n_start        = r_start;
        n_res_kind     = r_res_kind;
        n_res_conn     = r_res_conn;
        n_res_seq      = r_res_seq;
        n_res_last     = r_res_last;
        n_out_valid    = r_out_valid && !o_result.ready;
        n_out_kind     = r_out_kind;
        n_out_conn     = r_out_conn;
        n_out_seq      = r_out_seq;
        n_out_count    = r_out_count;
        n_out_earliest = r_out_earliest;
        n_out_last     = r_out_last;
        mem.we         = 1'b0;
        mem.waddr      = r_head;
        mem.wdata      = r_ins;
        mem.raddr      = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op       = i_item.opcode;
                    n_id       = i_item.conn_id;
                    n_now      = i_item.now_seconds;
                    n_exp      = exp_new;
                    n_res_kind = KIND_DONE;
                    n_res_conn = '0;
                    n_res_seq  = '0;
                    n_res_last = 1'b1;
                    case (i_item.opcode)
                        OP_ADD: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_res_kind = KIND_FULL;
                                n_state    = S_PUT;
                            end else begin
                                n_ins.expiry = exp_new;
                                n_ins.conn   = i_item.conn_id;
                                n_ins.seq    = i_item.conn_sequence;
                                n_p          = r_count;
                                n_state      = S_INS;
                            end
                        end
                        OP_DEL: begin
                            n_r     = '0;
                            n_w     = '0;
                            n_state = S_DEL_RD;
                        end
                        OP_POLL: begin
                            n_i     = '0;
                            n_start = r_count;
                            if (r_count == '0 || cmp_gt) begin
                                n_res_kind = KIND_NONE;
                                n_state    = S_PUT;
                            end else begin
                                n_state = S_POLL_RD;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_state = S_PUT;
                        end
                    endcase
                end
            end

            // shift the tail up one slot per step until the new entry fits
            S_INS: begin
                if (r_p == '0) begin
                    mem.we     = 1'b1;
                    mem.waddr  = r_head;
                    mem.wdata  = r_ins;
                    n_head_exp = r_ins.expiry;
                    n_count    = r_count + CNT_W'(1);
                    n_state    = (r_op == OP_POLL) ? S_POLL_REF : S_PUT;
                end else begin
                    mem.raddr = laddr(r_head, r_p - CNT_W'(1));
                    n_state   = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                mem.we    = 1'b1;
                mem.waddr = laddr(r_head, r_p);
                if (cmp_gt) begin
                    mem.wdata = i_rd_data;
                    n_p       = r_p - CNT_W'(1);
                    n_state   = S_INS;
                end else begin
                    mem.wdata = r_ins;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = (r_op == OP_POLL) ? S_POLL_REF : S_PUT;
                end
            end

            // compaction: read slot r, keep it at slot w unless it matches
            S_DEL_RD: begin
                if (r_r == r_count) begin
                    n_count = r_w;
                    n_state = S_PUT;
                end else begin
                    mem.raddr = laddr(r_head, r_r);
                    n_state   = S_DEL_CHK;
                end
            end

            S_DEL_CHK: begin
                n_r = r_r + CNT_W'(1);
                if (i_rd_data.conn != r_id) begin
                    mem.we    = 1'b1;
                    mem.waddr = laddr(r_head, r_w);
                    mem.wdata = i_rd_data;
                    n_w       = r_w + CNT_W'(1);
                    if (r_w == '0) begin
                        n_head_exp = i_rd_data.expiry;
                    end
                end
                n_state = S_DEL_RD;
            end

            S_POLL_RD: begin
                mem.raddr = r_head;
                n_state   = S_POLL_POP;
            end

            S_POLL_POP: begin
                n_res_kind   = KIND_EXPIRED;
                n_res_conn   = i_rd_data.conn;
                n_res_seq    = i_rd_data.seq;
                n_ins.expiry = r_exp;
                n_ins.conn   = i_rd_data.conn;
                n_ins.seq    = i_rd_data.seq;
                n_head       = ptr_add(r_head, PTR_W'(1));
                n_count      = r_count - CNT_W'(1);
                n_i          = r_i + CNT_W'(1);
                if (i_kick) begin
                    n_state = S_POLL_REF;
                end else begin
                    n_p     = r_count - CNT_W'(1);
                    n_state = S_INS;
                end
            end

            S_POLL_REF: begin
                if (r_count == '0) begin
                    n_res_last = 1'b1;
                    n_state    = S_PUT;
                end else begin
                    mem.raddr = r_head;
                    n_state   = S_POLL_REFW;
                end
            end

            // new head known: stop at the start count or at a later expiry
            S_POLL_REFW: begin
                n_head_exp = i_rd_data.expiry;
                n_res_last = (r_i == r_start) || cmp_gt;
                n_state    = S_PUT;
            end

            S_PUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid    = 1'b1;
                    n_out_kind     = r_res_kind;
                    n_out_conn     = r_res_conn;
                    n_out_seq      = r_res_seq;
                    n_out_count    = CNT_OUT_W'(r_count);
                    n_out_earliest = (r_count == '0) ? '0 : r_head_exp;
                    n_out_last     = r_res_last;
                    n_state        = r_res_last ? S_IDLE : S_POLL_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_id           <= n_id;
        r_now          <= n_now;
        r_exp          <= n_exp;
        r_ins          <= n_ins;
        r_head_exp     <= n_head_exp;
        r_p            <= n_p;
        r_r            <= n_r;
        r_w            <= n_w;
        r_i            <= n_i;
        r_start        <= n_start;
        r_res_kind     <= n_res_kind;
        r_res_conn     <= n_res_conn;
        r_res_seq      <= n_res_seq;
        r_res_last     <= n_res_last;
        r_out_kind     <= n_out_kind;
        r_out_conn     <= n_out_conn;
        r_out_seq      <= n_out_seq;
        r_out_count    <= n_out_count;
        r_out_earliest <= n_out_earliest;
        r_out_last     <= n_out_last;
    end

    assign o_mem                    = mem;
    assign i_item.ready             = (r_state == S_IDLE);
    assign o_result.valid           = r_out_valid;
    assign o_result.kind            = r_out_kind;
    assign o_result.out_conn_id     = r_out_conn;
    assign o_result.out_sequence    = r_out_seq;
    assign o_result.entry_count     = r_out_count;
    assign o_result.earliest_expiry = r_out_earliest;
    assign o_result.last            = r_out_last;

endmodule

FILE: rtl/connection_timeout_queue_unit.sv
// ----------------------------------------------------------------------------
// connection_timeout_queue_unit
// Sorted table of connection timers with add, delete, poll and clear.
//
// Channels: i_item takes one operation per beat (add, delete, poll, clear);
// o_result returns one beat per result, the final one of an operation with
// last set; i_cfg writes wait_time (index 0) and kick_on_timeout (index 1),
// which the user must write only while the unit is idle; the unit itself
// does not enforce it. Every result carries the entry count and the
// earliest expiry left in the table.
// One operation at a time; i_item.ready is high only between operations.
// Add shifts each entry with a later expiry up one slot; delete reads every
// entry; poll pops each expired head and, in re-arm mode, inserts it again.
// Each table step is a read, or a read then a write, of the entry memory
// with registered read data.
// Reset empties the table at once and loads wait_time 20 and kick mode on.
// A result waits in the output register while o_result.ready is low; the
// next operation is taken meanwhile, and the sequencer only holds when it
// has another result to hand over.
// ----------------------------------------------------------------------------
module connection_timeout_queue_unit import ctq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctq_cfg_if.sink      i_cfg,
    ctq_item_if.sink     i_item,
    ctq_result_if.source o_result
);

    logic [WAIT_W-1:0] r_wait_time;
    logic              r_kick;
    t_mem_req          mem_req;
    t_entry            rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_time <= WAIT_RESET;
            r_kick      <= KICK_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WAIT_TIME: r_wait_time <= i_cfg.data;
                CFG_KICK:      r_kick      <= i_cfg.data[0];
                default:       r_kick      <= r_kick;
            endcase
        end
    end

    ctq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wait_time (r_wait_time),
        .i_kick      (r_kick),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    ctq_table u_table (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

FILE: rtl/ctq_checker.sv
// ----------------------------------------------------------------------------
// ctq_checker
// Port-level checks of the connection timeout queue, bound to the top level.
// ----------------------------------------------------------------------------
module ctq_checker import ctq_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_item_valid,
    input logic                 i_item_ready,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [KIND_W-1:0]    i_res_kind,
    input logic [ID_W-1:0]      i_res_conn,
    input logic [SEQ_W-1:0]     i_res_seq,
    input logic [CNT_OUT_W-1:0] i_res_count,
    input logic [TIME_W-1:0]    i_res_earliest,
    input logic                 i_res_last
);

    // only expired-entry beats may continue a poll
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind != KIND_EXPIRED) |-> i_res_last)
        else $error("non-expiry result without last");

    // one operation in flight: no beat taken right after an accepted one
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item_ready |=> !i_item_ready)
        else $error("operation accepted while busy");

    a_empty_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_count == '0) |-> (i_res_earliest == '0))
        else $error("empty table reports an expiry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_count <= CNT_OUT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid &&
            $stable({i_res_kind, i_res_conn, i_res_seq, i_res_count,
                     i_res_earliest, i_res_last}))
        else $error("stalled result beat changed");

endmodule

bind connection_timeout_queue_unit ctq_checker u_ctq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_res_kind     (o_result.kind),
    .i_res_conn     (o_result.out_conn_id),
    .i_res_seq      (o_result.out_sequence),
    .i_res_count    (o_result.entry_count),
    .i_res_earliest (o_result.earliest_expiry),
    .i_res_last     (o_result.last)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for connection_timeout_queue_unit. A scoreboard keeps
// its own sorted timer table, predicts every result beat of each accepted
// operation, and compares the beats field by field in order. Directed
// operations cover an empty table, equal expiries, saturation and the
// poll bound. Random phases follow under several register settings and
// sender/receiver stall patterns; two of them fill the table past full.
// ----------------------------------------------------------------------------
module testbench import ctq_pkg::*; ();

    localparam int CYCLE_LIMIT = 25_000_000;
    localparam int SETTLE      = 2 * TABLE_DEPTH + 16;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        t_kind                kind;
        logic [ID_W-1:0]      conn;
        logic [SEQ_W-1:0]     seq;
        logic [CNT_OUT_W-1:0] count;
        logic [TIME_W-1:0]    earliest;
        logic                 last;
    } t_result_beat;

    class timer_queue_scoreboard;
        logic [TIME_W-1:0] slot_expiry [TABLE_DEPTH];
        logic [ID_W-1:0]   slot_conn   [TABLE_DEPTH];
        logic [SEQ_W-1:0]  slot_seq    [TABLE_DEPTH];
        int                held;
        logic [WAIT_W-1:0] wait_s;
        logic              kick;
        t_result_beat      pending_results[$];
        int                errors;
        int                ops_seen;
        int                beats_seen;
        int                full_refusals;
        int                expired_seen;
        int                peak_held;

        function new();
            held          = 0;
            wait_s        = WAIT_RESET;
            kick          = KICK_RESET;
            errors        = 0;
            ops_seen      = 0;
            beats_seen    = 0;
            full_refusals = 0;
            expired_seen  = 0;
            peak_held     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [WAIT_W-1:0] data);
            if (idx == CFG_WAIT_TIME) begin
                wait_s = data;
            end else begin
                kick = data[0];
            end
        endfunction

        // now + wait_time, saturating at all ones
        function logic [TIME_W-1:0] expiry_after(logic [TIME_W-1:0] now);
            logic [TIME_W:0] sum;
            sum = {1'b0, now} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_s};
            return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        endfunction

        // goes behind every entry with an expiry not later than e
        function void insert_timer(logic [TIME_W-1:0] e, logic [ID_W-1:0] id,
                                   logic [SEQ_W-1:0] seq);
            int p;
            p = held;
            while (p > 0 && slot_expiry[p-1] > e) begin
                slot_expiry[p] = slot_expiry[p-1];
                slot_conn[p]   = slot_conn[p-1];
                slot_seq[p]    = slot_seq[p-1];
                p--;
            end
            slot_expiry[p] = e;
            slot_conn[p]   = id;
            slot_seq[p]    = seq;
            held++;
        endfunction

        function void pop_head();
            int i;
            for (i = 1; i < held; i++) begin
                slot_expiry[i-1] = slot_expiry[i];
                slot_conn[i-1]   = slot_conn[i];
                slot_seq[i-1]    = slot_seq[i];
            end
            held--;
        endfunction

        function void queue_result(t_kind kind, logic [ID_W-1:0] id,
                                   logic [SEQ_W-1:0] seq, logic last);
            t_result_beat b;
            b.kind     = kind;
            b.conn     = id;
            b.seq      = seq;
            b.count    = CNT_OUT_W'(held);
            b.earliest = (held > 0) ? slot_expiry[0] : '0;
            b.last     = last;
            pending_results = {pending_results, b};
        endfunction

        function void note_operation(t_opcode op, logic [ID_W-1:0] id,
                                     logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] now);
            int               i;
            int               w;
            int               start;
            int               emitted;
            logic [ID_W-1:0]  cid;
            logic [SEQ_W-1:0] cseq;
            t_result_beat     tail;
            ops_seen++;
            case (op)
                OP_ADD: begin
                    if (held >= TABLE_DEPTH) begin
                        full_refusals++;
                        queue_result(KIND_FULL, '0, '0, 1'b1);
                    end else begin
                        insert_timer(expiry_after(now), id, seq);
                        queue_result(KIND_DONE, '0, '0, 1'b1);
                    end
                end
                OP_DEL: begin
                    w = 0;
                    for (i = 0; i < held; i++) begin
                        if (slot_conn[i] != id) begin
                            slot_expiry[w] = slot_expiry[i];
                            slot_conn[w]   = slot_conn[i];
                            slot_seq[w]    = slot_seq[i];
                            w++;
                        end
                    end
                    held = w;
                    queue_result(KIND_DONE, '0, '0, 1'b1);
                end
                OP_CLEAR: begin
                    held = 0;
                    queue_result(KIND_DONE, '0, '0, 1'b1);
                end
                default: begin
                    // poll: bounded by the count at the start, so re-armed
                    // entries still due are not emitted twice
                    start   = held;
                    emitted = 0;
                    for (i = 0; i < start; i++) begin
                        if (held == 0 || slot_expiry[0] > now) break;
                        cid  = slot_conn[0];
                        cseq = slot_seq[0];
                        pop_head();
                        if (!kick) insert_timer(expiry_after(now), cid, cseq);
                        queue_result(KIND_EXPIRED, cid, cseq, 1'b0);
                        emitted++;
                    end
                    if (emitted == 0) begin
                        queue_result(KIND_NONE, '0, '0, 1'b1);
                    end else begin
                        tail      = pending_results[pending_results.size() - 1];
                        tail.last = 1'b1;
                        pending_results[pending_results.size() - 1] = tail;
                    end
                end
            endcase
            if (held > peak_held) peak_held = held;
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("[%0t] MISMATCH beat %0d %s: expected %0h got %0h",
                     $time, beats_seen, what, want, got);
        endtask

        task check_result(t_result_beat got);
            t_result_beat want;
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing outstanding", '0, 64'(got.kind));
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (want.kind == KIND_EXPIRED) expired_seen++;
            if (got.kind !== want.kind) begin
                report_mismatch("kind", 64'(want.kind), 64'(got.kind));
            end
            if (got.conn !== want.conn) begin
                report_mismatch("out_conn_id", 64'(want.conn), 64'(got.conn));
            end
            if (got.seq !== want.seq) begin
                report_mismatch("out_sequence", 64'(want.seq), 64'(got.seq));
            end
            if (got.count !== want.count) begin
                report_mismatch("entry_count", 64'(want.count), 64'(got.count));
            end
            if (got.earliest !== want.earliest) begin
                report_mismatch("earliest_expiry", 64'(want.earliest), 64'(got.earliest));
            end
            if (got.last !== want.last) begin
                report_mismatch("last", 64'(want.last), 64'(got.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ctq_cfg_if    cfg_bus ();
    ctq_item_if   item_bus ();
    ctq_result_if result_bus ();

    connection_timeout_queue_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    timer_queue_scoreboard sb;
    int                    sender_idle_pct;
    int                    receiver_idle_pct;
    int                    cycle_count;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        result_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result_beat got;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got.kind     = result_bus.kind;
            got.conn     = result_bus.out_conn_id;
            got.seq      = result_bus.out_sequence;
            got.count    = result_bus.entry_count;
            got.earliest = result_bus.earliest_expiry;
            got.last     = result_bus.last;
            sb.check_result(got);
        end
    end

    // leaves valid high after the beat; a drain or an idle gap in the next call lowers it
    task automatic send_item(t_opcode op, logic [ID_W-1:0] id, logic [SEQ_W-1:0] seq,
                             logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.opcode        <= op;
        item_bus.conn_id       <= id;
        item_bus.conn_sequence <= seq;
        item_bus.now_seconds   <= now;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        sb.note_operation(op, id, seq, now);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [WAIT_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // registers change only with the block idle and every beat taken
    task automatic reconfigure(logic [WAIT_W-1:0] wait_s, logic kick);
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        write_register(CFG_WAIT_TIME, wait_s);
        write_register(CFG_KICK, {{(WAIT_W - 1){1'b0}}, kick});
    endtask

    function automatic logic [ID_W-1:0] pick_conn();
        if ($urandom_range(0, 4) == 0) return ID_W'($urandom);
        return ID_W'($urandom_range(0, 7));
    endfunction

    task automatic run_directed();
        // reset settings: wait 20, kick on
        send_item(OP_POLL, 16'd0, 32'd0, 32'd0);
        send_item(OP_DEL, 16'd0, 32'd0, 32'd0);
        send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0);
        send_item(OP_ADD, 16'h0000, 32'h0000_0000, 32'd0);
        send_item(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_ADD, 16'd1, 32'd1, 32'd5);
        send_item(OP_ADD, 16'd2, 32'd2, 32'hFFFF_FFFF);
        send_item(OP_ADD, 16'd3, 32'd3, 32'd1);
        send_item(OP_POLL, 16'd0, 32'd0, 32'd19);
        send_item(OP_POLL, 16'd0, 32'd0, 32'd21);
        send_item(OP_DEL, 16'd1, 32'd0, 32'd0);
        send_item(OP_ADD, 16'd4, 32'h1234_5678, 32'd100);
        send_item(OP_ADD, 16'd4, 32'h8765_4321, 32'd90);
        send_item(OP_ADD, 16'd5, 32'hA5A5_5A5A, 32'd95);
        send_item(OP_DEL, 16'd4, 32'd0, 32'd0);
        send_item(OP_POLL, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_POLL, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_ADD, 16'd6, 32'd6, 32'd7);
        send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0);
        // longest wait, re-arm mode: saturated re-arms stay due in the same poll
        reconfigure(16'hFFFF, 1'b0);
        send_item(OP_ADD, 16'd7, 32'd7, 32'hFFFF_0000);
        send_item(OP_ADD, 16'd8, 32'd8, 32'hFFFF_FFF0);
        send_item(OP_POLL, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_POLL, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_POLL, 16'd0, 32'd0, 32'hFFFF_0000);
        send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0);
    endtask

    task automatic run_random_phase(logic [TIME_W-1:0] base, bit with_fill);
        int                k;
        int                r;
        t_opcode           op;
        logic [TIME_W-1:0] clock_s;
        logic [TIME_W-1:0] now;
        clock_s = base;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            if (with_fill && k == PHASE_ITEMS / 4) begin
                while (sb.held < TABLE_DEPTH) begin
                    send_item(OP_ADD, pick_conn(), $urandom, clock_s);
                end
                repeat (3) send_item(OP_ADD, pick_conn(), $urandom, clock_s);
            end
            clock_s = clock_s + $urandom_range(0, sb.wait_s / 8 + 1);
            r  = $urandom_range(0, 99);
            op = (r < 45) ? OP_ADD : (r < 78) ? OP_POLL : (r < 93) ? OP_DEL : OP_CLEAR;
            now = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : clock_s;
            send_item(op, pick_conn(), $urandom, now);
            if ($urandom_range(0, 39) == 0) wait_results_drained();
        end
    endtask

    initial begin
        int ph;
        sb                     = new();
        cycle_count            = 0;
        sender_idle_pct        = 16;
        receiver_idle_pct      = 68;
        i_rst_n                = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_WAIT_TIME;
        cfg_bus.data           = '0;
        item_bus.valid         = 1'b0;
        item_bus.opcode        = OP_ADD;
        item_bus.conn_id       = '0;
        item_bus.conn_sequence = '0;
        item_bus.now_seconds   = '0;
        result_bus.ready       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (ph = 0; ph < 6; ph++) begin
            sender_idle_pct   = (ph < 2) ? 16 : (ph < 4) ? 68 : 0;
            receiver_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 16 : 0;
            case (ph)
                0: reconfigure(16'd1, 1'b0);
                1: reconfigure(WAIT_W'($urandom_range(2, 60)), 1'b1);
                2: reconfigure(16'hFFFF, 1'b1);
                3: reconfigure(WAIT_W'($urandom_range(2, 500)), 1'b0);
                4: reconfigure(16'hFFFF, 1'b0);
                default: reconfigure(16'd1, 1'b1);
            endcase
            // phase 4 starts near the top of time to hit saturation and wrap
            run_random_phase((ph == 4) ? 32'hFFFE_0000 : TIME_W'($urandom),
                             (ph == 1 || ph == 4));
        end

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d ops, %0d beats, %0d expired, %0d full refusals, peak %0d/%0d.",
                 sb.ops_seen, sb.beats_seen, sb.expired_seen, sb.full_refusals,
                 sb.peak_held, TABLE_DEPTH);
        $display("Wait 1..65535 s, kick and re-arm, stalls both sides and none; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
